/* sv/wtns_pkg.sv */
// ----------------------------------------------------------------------------
// Wavetable note sequencer package
// Field widths, item kind codes and packed item layouts shared by the
// sequencer and its checker.
// ----------------------------------------------------------------------------
package wtns_pkg;

    // Field widths.
    localparam int NOTE_AW  = 7;   // note store address
    localparam int TONE_W   = 5;   // tone number
    localparam int SIZE_W   = 9;   // samples per tone period
    localparam int TICKS_W  = 16;  // note length in ticks
    localparam int OFFS_W   = 8;   // sample offset within a tone
    localparam int SMP_W    = 16;  // audio sample word
    localparam int NCNT_W   = 8;   // notes in a song
    localparam int KIND_W   = 2;

    // Store geometry, set by the field widths.
    localparam int NOTE_DEPTH = 1 << NOTE_AW;
    localparam int SMP_AW     = TONE_W + OFFS_W;
    localparam int SMP_DEPTH  = 1 << SMP_AW;

    // Packed input payload width, rounded up to whole bytes.
    localparam int IN_BITS   = NOTE_AW + TONE_W + SIZE_W + TICKS_W + OFFS_W
                               + SMP_W + NOTE_AW + NCNT_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // Item kinds carried on the input tuser.
    localparam logic [KIND_W-1:0] KIND_LOAD_NOTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK        = 2'd3;

    // One note store entry.
    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic [SIZE_W-1:0]  size;
        logic [TONE_W-1:0]  tone;
    } t_note_entry;

    // Input tdata layout, first field in the lowest bits.
    typedef struct packed {
        logic [IN_DATA_W-IN_BITS-1:0] pad;
        logic [NCNT_W-1:0]            song_notes;
        logic [NOTE_AW-1:0]           song_base;
        logic [SMP_W-1:0]             sample_value;
        logic [OFFS_W-1:0]            sample_offset;
        logic [TICKS_W-1:0]           note_ticks;
        logic [SIZE_W-1:0]            note_size;
        logic [TONE_W-1:0]            tone;
        logic [NOTE_AW-1:0]           note_addr;
    } t_in_item;

endpackage

/* sv/wavetable_note_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Wavetable note sequencer
// Holds a note store and a per-tone sample store in synchronous memories and
// plays a song from them, one sample per tick transaction while a song plays.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  -------   ---------  ------------------------------------------------------
//  s_axis    in         tuser: kind; tdata: note and sample load, start fields
//  m_axis    out        tdata: sample_out; tlast: song_end
//
// A load is written straight into its store. A start reads the first note
// from the note store. A tick while playing checks the note state, then reads
// the sample store; when it moves on to the next note, the note store read
// comes first. The song-end tick and an idle tick need no read. The input
// stalls while a read is in flight and while a result is held that the output
// side is not taking. Reset is synchronous and active low; the memories are
// not cleared.
//
module wavetable_note_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata, low to high: note_addr, tone, note_size, note_ticks,
    // sample_offset, sample_value, song_base, song_notes, zero fill.
    input  logic [wtns_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind.
    input  logic [wtns_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: sample_out.
    output logic [wtns_pkg::SMP_W-1:0]      o_m_axis_tdata,
    // tlast: song_end.
    output logic                            o_m_axis_tlast
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_NOTE   = 2'd1;
    localparam logic [1:0] ST_SAMPLE = 2'd2;

    // Memories.
    wtns_pkg::t_note_entry          note_mem [wtns_pkg::NOTE_DEPTH];
    logic [wtns_pkg::SMP_W-1:0]     smp_mem  [wtns_pkg::SMP_DEPTH];

    // Control and playback registers.
    logic [1:0]                     r_state, n_state;
    logic                           r_playing, n_playing;
    logic                           r_advance, n_advance;
    logic [wtns_pkg::NCNT_W-1:0]    r_note_pos, n_note_pos;
    logic [wtns_pkg::SIZE_W-1:0]    r_sample_pos, n_sample_pos;
    logic [wtns_pkg::TICKS_W-1:0]   r_tick_count, n_tick_count;
    logic [wtns_pkg::TONE_W-1:0]    r_cur_tone, n_cur_tone;
    logic [wtns_pkg::SIZE_W-1:0]    r_cur_size, n_cur_size;
    logic [wtns_pkg::TICKS_W-1:0]   r_cur_ticks, n_cur_ticks;
    logic [wtns_pkg::NOTE_AW-1:0]   r_first_note, n_first_note;
    logic [wtns_pkg::NCNT_W-1:0]    r_note_count, n_note_count;
    logic                           r_out_valid, n_out_valid;
    logic [wtns_pkg::SMP_W-1:0]     r_out_data, n_out_data;
    logic                           r_out_last, n_out_last;

    // Memory ports.
    logic                           note_we, note_re;
    logic [wtns_pkg::NOTE_AW-1:0]   note_waddr, note_raddr;
    wtns_pkg::t_note_entry          note_wdata;
    wtns_pkg::t_note_entry          r_note_rdata;
    logic                           smp_we, smp_re;
    logic [wtns_pkg::SMP_AW-1:0]    smp_waddr, smp_raddr;
    logic [wtns_pkg::SMP_W-1:0]     r_smp_rdata;

    // Decoded input and helpers.
    wtns_pkg::t_in_item             in_item;
    logic                           in_acc;
    logic [wtns_pkg::NCNT_W:0]      next_pos;
    logic [wtns_pkg::SIZE_W-1:0]    wrap_pos;

    assign in_item         = wtns_pkg::t_in_item'(i_s_axis_tdata);
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Next note index and the looped sample position.
    assign next_pos = {1'b0, r_note_pos} + 1'b1;
    assign wrap_pos = ((r_sample_pos >= r_cur_size) || r_sample_pos[wtns_pkg::SIZE_W-1])
                      ? '0 : r_sample_pos;

    // Sequencer: decode transactions, issue reads, take read data.
    always_comb begin
        n_state      = r_state;
        n_playing    = r_playing;
        n_advance    = r_advance;
        n_note_pos   = r_note_pos;
        n_sample_pos = r_sample_pos;
        n_tick_count = r_tick_count;
        n_cur_tone   = r_cur_tone;
        n_cur_size   = r_cur_size;
        n_cur_ticks  = r_cur_ticks;
        n_first_note = r_first_note;
        n_note_count = r_note_count;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        note_we      = 1'b0;
        note_re      = 1'b0;
        note_waddr   = in_item.note_addr;
        note_raddr   = in_item.song_base;
        note_wdata   = '{ticks: in_item.note_ticks, size: in_item.note_size,
                         tone: in_item.tone};
        smp_we       = 1'b0;
        smp_re       = 1'b0;
        smp_waddr    = {in_item.tone, in_item.sample_offset};
        smp_raddr    = {r_cur_tone, wrap_pos[wtns_pkg::OFFS_W-1:0]};

        // A held result leaves when the output side takes it.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_s_axis_tuser)
                        wtns_pkg::KIND_LOAD_NOTE: begin
                            note_we = 1'b1;
                        end
                        wtns_pkg::KIND_LOAD_SAMPLE: begin
                            smp_we = 1'b1;
                        end
                        wtns_pkg::KIND_START: begin
                            n_first_note = in_item.song_base;
                            n_note_count = in_item.song_notes;
                            n_note_pos   = '0;
                            n_tick_count = '0;
                            n_sample_pos = '0;
                            n_playing    = 1'b1;
                            n_advance    = 1'b0;
                            note_re      = 1'b1;
                            n_state      = ST_NOTE;
                        end
                        wtns_pkg::KIND_TICK: begin
                            if (r_playing) begin
                                if (r_tick_count >= r_cur_ticks) begin
                                    if (next_pos >= {1'b0, r_note_count}) begin
                                        // Song finished: zero sample with end mark.
                                        n_playing   = 1'b0;
                                        n_note_pos  = next_pos[wtns_pkg::NCNT_W-1:0];
                                        n_out_valid = 1'b1;
                                        n_out_data  = '0;
                                        n_out_last  = 1'b1;
                                    end else begin
                                        n_note_pos = next_pos[wtns_pkg::NCNT_W-1:0];
                                        note_raddr = r_first_note
                                                     + next_pos[wtns_pkg::NOTE_AW-1:0];
                                        note_re    = 1'b1;
                                        n_advance  = 1'b1;
                                        n_state    = ST_NOTE;
                                    end
                                end else begin
                                    smp_re       = 1'b1;
                                    n_tick_count = r_tick_count + 1'b1;
                                    n_sample_pos = wrap_pos + 1'b1;
                                    n_state      = ST_SAMPLE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NOTE: begin
                n_cur_tone  = r_note_rdata.tone;
                n_cur_size  = r_note_rdata.size;
                n_cur_ticks = r_note_rdata.ticks;
                if (r_advance) begin
                    // New note starts at sample zero and counts this tick.
                    smp_raddr    = {r_note_rdata.tone, {wtns_pkg::OFFS_W{1'b0}}};
                    smp_re       = 1'b1;
                    n_tick_count = {{(wtns_pkg::TICKS_W-1){1'b0}}, 1'b1};
                    n_sample_pos = {{(wtns_pkg::SIZE_W-1){1'b0}}, 1'b1};
                    n_state      = ST_SAMPLE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SAMPLE: begin
                n_out_valid = 1'b1;
                n_out_data  = r_smp_rdata;
                n_out_last  = 1'b0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Note store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (note_we) begin
            note_mem[note_waddr] <= note_wdata;
        end
        if (note_re) begin
            r_note_rdata <= note_mem[note_raddr];
        end
    end

    // Sample store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            smp_mem[smp_waddr] <= in_item.sample_value;
        end
        if (smp_re) begin
            r_smp_rdata <= smp_mem[smp_raddr];
        end
    end

    // Control and playback state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_playing    <= 1'b0;
            r_advance    <= 1'b0;
            r_note_pos   <= '0;
            r_sample_pos <= '0;
            r_tick_count <= '0;
            r_cur_tone   <= '0;
            r_cur_size   <= '0;
            r_cur_ticks  <= '0;
            r_first_note <= '0;
            r_note_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_playing    <= n_playing;
            r_advance    <= n_advance;
            r_note_pos   <= n_note_pos;
            r_sample_pos <= n_sample_pos;
            r_tick_count <= n_tick_count;
            r_cur_tone   <= n_cur_tone;
            r_cur_size   <= n_cur_size;
            r_cur_ticks  <= n_cur_ticks;
            r_first_note <= n_first_note;
            r_note_count <= n_note_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

endmodule

/* sv/wtns_checker.sv */
// ----------------------------------------------------------------------------
// Wavetable note sequencer checker
// Port-level properties of the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wtns_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [wtns_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [wtns_pkg::KIND_W-1:0]     i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [wtns_pkg::SMP_W-1:0]      o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    logic in_acc;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // The song-end result always carries a zero sample.
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata == '0)
        else $error("song end with nonzero sample");

    // A load transaction never produces a result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_m_axis_tvalid &&
        (i_s_axis_tuser == wtns_pkg::KIND_LOAD_NOTE ||
         i_s_axis_tuser == wtns_pkg::KIND_LOAD_SAMPLE) |=> !o_m_axis_tvalid)
        else $error("result after a load");

    // A start reads the first note, so the input is not ready in the cycle after it.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_axis_tuser == wtns_pkg::KIND_START |=> !o_s_axis_tready)
        else $error("input ready during first note fetch");

endmodule

bind wavetable_note_sequencer_unit wtns_checker u_wtns_checker (.*);
